[src/brb_pkg.sv]
// shared types and constants for the byte ring buffer
`timescale 1ns / 1ps

package brb_pkg;

    localparam int QDEPTH = 4;
    localparam int QA_W   = 2;
    localparam int QC_W   = 3;

    typedef enum logic [2:0] {
        OP_WRITE  = 3'd0,
        OP_READ   = 3'd1,
        OP_PEEK   = 3'd2,
        OP_REMOVE = 3'd3,
        OP_CLEAR  = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_NO_DATA   = 2'd2,
        ST_NOT_ENOUGH = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_STREAM
    } t_state;

    typedef struct packed {
        logic [2:0] op;
        logic       first_of_block;
        logic [6:0] length;
        logic [7:0] data_in;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  data_out;
        logic        data_valid;
        logic [10:0] fill_level;
        logic        last;
    } t_out;

    typedef struct packed {
        logic valid;
        t_out item;
    } t_push;

endpackage

[src/brb_ram.sv]
// byte store: one write port, one registered read port
`timescale 1ns / 1ps

module brb_ram
    import brb_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/brb_outq.sv]
// small result queue between the controller and the output channel
`timescale 1ns / 1ps

module brb_outq
    import brb_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_push           i_push,
    output logic [QC_W-1:0] o_count,
    output logic            o_valid,
    input  logic            i_stall,
    output t_out            o_data
);

    t_out            r_buf [QDEPTH];
    logic [QA_W-1:0] r_head;
    logic [QA_W-1:0] r_tail;
    logic [QC_W-1:0] r_count;
    logic [QA_W-1:0] n_head;
    logic [QA_W-1:0] n_tail;
    logic [QC_W-1:0] n_count;
    logic            pop;

    assign pop = o_valid && !i_stall;

    always_comb begin
        n_head  = pop ? r_head + 1'b1 : r_head;
        n_tail  = i_push.valid ? r_tail + 1'b1 : r_tail;
        n_count = r_count + QC_W'(i_push.valid) - QC_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_buf[r_tail] <= i_push.item;
        end
    end

    assign o_count = r_count;
    assign o_valid = (r_count != '0);
    assign o_data  = r_buf[r_head];

endmodule

[src/brb_ctrl.sv]
// request decode, ring pointers, fill count and byte streaming sequencer
`timescale 1ns / 1ps

module brb_ctrl
    import brb_pkg::*;
#(
    parameter int DEPTH       = 1024,
    parameter int MAX_REQUEST = 64,
    parameter int AW          = 10,
    parameter int FW          = 11
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  t_in             i_in_data,
    input  logic [QC_W-1:0] i_q_count,
    output t_push           o_push,
    output logic            o_mem_we,
    output logic [AW-1:0]   o_mem_waddr,
    output logic [7:0]      o_mem_wdata,
    output logic            o_mem_re,
    output logic [AW-1:0]   o_mem_raddr,
    input  logic [7:0]      i_mem_rdata
);

    localparam int CW = (FW > 7) ? FW : 7;
    localparam int SW = ((AW > 7) ? AW : 7) + 1;

    t_state        r_state, n_state;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic [AW-1:0] r_wr_idx, n_wr_idx;
    logic [FW-1:0] r_fill, n_fill;
    logic [6:0]    r_blk_rem, n_blk_rem;
    logic          r_blk_rej, n_blk_rej;
    logic [AW-1:0] r_cursor, n_cursor;
    logic [6:0]    r_left, n_left;
    logic          r_consume, n_consume;
    logic          r_pend;
    logic          r_pend_last;

    logic          accept;
    logic          issue;
    logic          single;
    logic          start;
    logic [1:0]    st;
    logic [6:0]    len_c;
    logic [6:0]    rd_n;
    logic [FW-1:0] free;
    logic          wr_ok;
    logic [SW-1:0] sum;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // handshake and issue control
    always_comb begin
        o_in_stall = !(r_state == S_IDLE && !r_pend && i_q_count < QC_W'(QDEPTH));
        accept     = i_in_valid && !o_in_stall;
        // reserve a queue slot for the byte already in flight
        issue      = (r_state == S_STREAM) &&
                     ((QC_W + 1)'(i_q_count) + (QC_W + 1)'(r_pend) + 1'b1
                      <= (QC_W + 1)'(QDEPTH));
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && start) begin
                    n_state = S_STREAM;
                end
            end
            S_STREAM: begin
                if (issue && r_left == 7'd1) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_rd_idx  = r_rd_idx;
        n_wr_idx  = r_wr_idx;
        n_fill    = r_fill;
        n_blk_rem = r_blk_rem;
        n_blk_rej = r_blk_rej;
        n_cursor  = r_cursor;
        n_left    = r_left;
        n_consume = r_consume;
        st        = ST_OK;
        single    = 1'b0;
        start     = 1'b0;
        wr_ok     = 1'b0;
        o_mem_we  = 1'b0;
        o_mem_re  = 1'b0;

        len_c = (i_in_data.length > 7'(MAX_REQUEST)) ? 7'(MAX_REQUEST) : i_in_data.length;
        rd_n  = (CW'(len_c) < CW'(r_fill)) ? len_c : 7'(r_fill);
        free  = FW'(DEPTH) - r_fill;
        sum   = SW'(r_rd_idx) + SW'(len_c);

        if (accept) begin
            single = 1'b1;
            case (i_in_data.op)
                OP_WRITE: begin
                    if (i_in_data.first_of_block) begin
                        if (len_c == 7'd0) begin
                            n_blk_rem = '0;
                            n_blk_rej = 1'b0;
                        end else begin
                            n_blk_rem = len_c - 1'b1;
                            n_blk_rej = CW'(free) < CW'(len_c);
                            wr_ok     = !n_blk_rej;
                        end
                    end else if (r_blk_rem != 7'd0) begin
                        n_blk_rem = r_blk_rem - 1'b1;
                        wr_ok     = !r_blk_rej;
                    end
                    if (wr_ok && r_fill < FW'(DEPTH)) begin
                        o_mem_we = 1'b1;
                        n_wr_idx = ring_next(r_wr_idx);
                        n_fill   = r_fill + 1'b1;
                    end else begin
                        st = ST_OVERFLOW;
                    end
                end
                OP_READ: begin
                    if (r_fill == '0) begin
                        st = ST_NO_DATA;
                    end else if (rd_n != 7'd0) begin
                        start     = 1'b1;
                        single    = 1'b0;
                        n_fill    = r_fill - FW'(rd_n);
                        n_cursor  = r_rd_idx;
                        n_left    = rd_n;
                        n_consume = 1'b1;
                    end
                end
                OP_PEEK: begin
                    if (CW'(r_fill) < CW'(len_c)) begin
                        st = ST_NOT_ENOUGH;
                    end else if (len_c != 7'd0) begin
                        start     = 1'b1;
                        single    = 1'b0;
                        n_cursor  = r_rd_idx;
                        n_left    = len_c;
                        n_consume = 1'b0;
                    end
                end
                OP_REMOVE: begin
                    if (CW'(r_fill) < CW'(len_c)) begin
                        st = ST_NOT_ENOUGH;
                    end else begin
                        n_rd_idx = AW'((sum >= SW'(DEPTH)) ? sum - SW'(DEPTH) : sum);
                        n_fill   = r_fill - FW'(len_c);
                    end
                end
                OP_CLEAR: begin
                    n_rd_idx  = '0;
                    n_wr_idx  = '0;
                    n_fill    = '0;
                    n_blk_rem = '0;
                    n_blk_rej = 1'b0;
                end
                default: begin
                end
            endcase
        end

        if (issue) begin
            o_mem_re = 1'b1;
            n_cursor = ring_next(r_cursor);
            n_left   = r_left - 1'b1;
            if (r_consume && r_left == 7'd1) begin
                n_rd_idx = ring_next(r_cursor);
            end
        end
    end

    always_comb begin
        o_mem_waddr = r_wr_idx;
        o_mem_wdata = i_in_data.data_in;
        o_mem_raddr = r_cursor;

        o_push.valid = (accept && single) || r_pend;
        if (r_pend) begin
            o_push.item.status     = ST_OK;
            o_push.item.data_out   = i_mem_rdata;
            o_push.item.data_valid = 1'b1;
            o_push.item.fill_level = 11'(r_fill);
            o_push.item.last       = r_pend_last;
        end else begin
            o_push.item.status     = st;
            o_push.item.data_out   = 8'd0;
            o_push.item.data_valid = 1'b0;
            o_push.item.fill_level = 11'(n_fill);
            o_push.item.last       = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rd_idx    <= '0;
            r_wr_idx    <= '0;
            r_fill      <= '0;
            r_blk_rem   <= '0;
            r_blk_rej   <= 1'b0;
            r_left      <= '0;
            r_consume   <= 1'b0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rd_idx    <= n_rd_idx;
            r_wr_idx    <= n_wr_idx;
            r_fill      <= n_fill;
            r_blk_rem   <= n_blk_rem;
            r_blk_rej   <= n_blk_rej;
            r_left      <= n_left;
            r_consume   <= n_consume;
            r_pend      <= issue;
            r_pend_last <= (r_left == 7'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cursor <= n_cursor;
    end

endmodule

[src/byte_ring_buffer.sv]
// byte ring buffer top level: controller, byte store and result queue
//
//  channel  dir  handshake                 payload
//  in       in   i_in_valid / o_in_stall   i_in_data  (t_in)
//  out      out  o_out_valid / i_out_stall o_out_data (t_out)
//
// write, remove, clear and failing requests each push a single result when accepted
// read and peek of n bytes stall the input from accept until the last byte is pushed:
// one byte per cycle through the store's single read port, while the queue has room
// a four-entry result queue decouples the output; the input stalls when it is full
// synchronous reset clears pointers, fill count and block state; the store is not cleared
`timescale 1ns / 1ps

module byte_ring_buffer
    import brb_pkg::*;
#(
    parameter int DEPTH       = 1024,
    parameter int MAX_REQUEST = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);

    logic [QC_W-1:0] q_count;
    t_push           push;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [7:0]      mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    logic [7:0]      mem_rdata;

    brb_ctrl #(
        .DEPTH       (DEPTH),
        .MAX_REQUEST (MAX_REQUEST),
        .AW          (AW),
        .FW          (FW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_q_count   (q_count),
        .o_push      (push),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    brb_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    brb_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_count (q_count),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data)
    );

    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= QC_W'(QDEPTH))
        else $error("result queue count out of range");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.valid && !(o_out_valid && !i_out_stall) |-> q_count < QC_W'(QDEPTH))
        else $error("result pushed into full queue");

    a_mid_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.valid && !push.item.last |-> push.item.data_valid)
        else $error("non-final result without a byte");

    a_no_accept_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.valid && !push.item.last |-> o_in_stall)
        else $error("request accepted while a byte stream runs");

endmodule
